[rtl/wsfd_pkg.sv]
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the websocket frame decoder
// Result record passed from the parser to the output buffer, and the
// length codes of the second header byte and the extended-length end counts.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // seven-bit length codes
  localparam logic [6:0] LEN7_MAX    = 7'd125;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;

  // header byte counts at which the extended length is complete
  localparam logic [3:0] EXT16_END = 4'd4;
  localparam logic [3:0] EXT64_END = 4'd10;

  // one result of the parser
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        fin_flag;
    logic [2:0]  rsv_bits;
    logic [3:0]  opcode;
    logic        was_masked;
    logic [63:0] frame_length;
    logic [3:0]  header_length;
    logic        first_byte;
    logic        last_byte;
    logic        empty_frame;
  } result_t;

endpackage

[rtl/wsfd_in_if.sv]
// ----------------------------------------------------------------------------
// wsfd_in_if: raw byte stream channel
// Valid/ready channel carrying one stream byte per transfer.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/wsfd_out_if.sv]
// ----------------------------------------------------------------------------
// wsfd_out_if: decoded payload channel
// Valid/ready channel carrying one payload byte and its frame header fields.
// ----------------------------------------------------------------------------
interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        fin_flag;
  logic [2:0]  rsv_bits;
  logic [3:0]  opcode;
  logic        was_masked;
  logic [63:0] frame_length;
  logic [3:0]  header_length;
  logic        first_byte;
  logic        last_byte;
  logic        empty_frame;

  modport source (
    output valid, output data_byte, output fin_flag, output rsv_bits, output opcode,
    output was_masked, output frame_length, output header_length, output first_byte,
    output last_byte, output empty_frame, input ready
  );
  modport sink (
    input valid, input data_byte, input fin_flag, input rsv_bits, input opcode,
    input was_masked, input frame_length, input header_length, input first_byte,
    input last_byte, input empty_frame, output ready
  );
endinterface

[rtl/websocket_frame_decoder.sv]
// ----------------------------------------------------------------------------
// websocket_frame_decoder: frame parser for a websocket byte stream
// Parses back-to-back frames and delivers unmasked payload bytes with
// their header fields.
// ----------------------------------------------------------------------------
// Usage
//   byte_stream: raw frame bytes, one per transfer, valid/ready.
//   result: one transfer per payload byte, carrying the unmasked byte, the
//     FIN/RSV/opcode bits, the mask flag, the decoded length, the header
//     length and first/last marks. A zero-length frame gives one transfer
//     flagged empty on the byte that ends its header.
//   Header bytes give no transfer on result, but for the empty-frame one.
// Timing
//   One byte per clock sustained while the skid entry is free. A result is
//   formed from the byte taken and the updated parse state and registered
//   in the output register, or in the skid entry while result is stalled.
// Reset
//   rst (synchronous) returns the parser to the first header byte and
//   empties the output register and skid entry.
// Stall
//   While result is stalled one further result is held in the skid entry;
//   byte_stream.ready drops only while that entry is occupied.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
  input  logic              clk,
  input  logic              rst,
  wsfd_in_if.sink           byte_stream,
  wsfd_out_if.source        result
);

  logic              take;
  logic              res_valid;
  wsfd_pkg::result_t res;
  logic              can_push;
  wsfd_pkg::result_t out_data;

  assign byte_stream.ready = can_push;
  assign take              = byte_stream.valid && can_push;

  // frame parser
  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (byte_stream.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register and skid
  wsfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // result fields
  assign result.data_byte     = out_data.data_byte;
  assign result.fin_flag      = out_data.fin_flag;
  assign result.rsv_bits      = out_data.rsv_bits;
  assign result.opcode        = out_data.opcode;
  assign result.was_masked    = out_data.was_masked;
  assign result.frame_length  = out_data.frame_length;
  assign result.header_length = out_data.header_length;
  assign result.first_byte    = out_data.first_byte;
  assign result.last_byte     = out_data.last_byte;
  assign result.empty_frame   = out_data.empty_frame;

endmodule

[rtl/wsfd_parser.sv]
// ----------------------------------------------------------------------------
// wsfd_parser: frame header and payload parser
// Holds the parse state; for each byte taken it updates the state and
// forms at most one result from the byte and the updated header fields.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [7:0]  hdr0, hdr0_next;
  logic        mask_on, mask_on_next;
  logic [63:0] pay_len, pay_len_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_idx, mask_idx_next;

  logic        len_done;
  logic        hdr_done;
  logic        emit;
  logic        first_flag, last_flag, empty_flag;
  logic [7:0]  key_byte;
  logic [7:0]  data_out;

  // key byte for the current payload position, first key byte in the top bits
  always_comb begin
    unique case (mask_idx)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state and result for the byte on the input
  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    hdr0_next      = hdr0;
    mask_on_next   = mask_on;
    pay_len_next   = pay_len;
    remaining_next = remaining;
    mask_key_next  = mask_key;
    mask_idx_next  = mask_idx;
    len_done       = 1'b0;
    hdr_done       = 1'b0;
    emit           = 1'b0;
    first_flag     = 1'b0;
    last_flag      = 1'b0;
    empty_flag     = 1'b0;
    data_out       = 8'd0;

    unique case (phase)
      PH_HDR1: begin
        mask_on_next   = in_byte[7];
        hdr_count_next = 4'd2;
        mask_key_next  = 32'd0;
        if (in_byte[6:0] <= wsfd_pkg::LEN7_MAX) begin
          pay_len_next = {57'd0, in_byte[6:0]};
          len_done     = 1'b1;
        end else begin
          pay_len_next = 64'd0;
          phase_next   = (in_byte[6:0] == wsfd_pkg::LEN_CODE_16) ? PH_EXT16 : PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        pay_len_next   = {pay_len[55:0], in_byte};
        hdr_count_next = hdr_count + 4'd1;
        if ((phase == PH_EXT16 && hdr_count_next == wsfd_pkg::EXT16_END) ||
            (phase == PH_EXT64 && hdr_count_next == wsfd_pkg::EXT64_END)) begin
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next  = {mask_key[23:0], in_byte};
        hdr_count_next = hdr_count + 4'd1;
        if (mask_idx == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          mask_idx_next = mask_idx + 2'd1;
        end
      end
      PH_DATA: begin
        emit           = 1'b1;
        data_out       = in_byte ^ (mask_on ? key_byte : 8'd0);
        first_flag     = (remaining == pay_len);
        last_flag      = (remaining == 64'd1);
        remaining_next = remaining - 64'd1;
        mask_idx_next  = mask_idx + 2'd1;
        if (remaining == 64'd1) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        hdr0_next      = in_byte;
        hdr_count_next = 4'd1;
        phase_next     = PH_HDR1;
      end
    endcase

    // length known: go for the key or close the header
    if (len_done) begin
      if (mask_on_next) begin
        phase_next    = PH_MASK;
        mask_idx_next = 2'd0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: empty frame result or start of payload
    if (hdr_done) begin
      mask_idx_next = 2'd0;
      if (pay_len_next == 64'd0) begin
        emit       = 1'b1;
        first_flag = 1'b1;
        last_flag  = 1'b1;
        empty_flag = 1'b1;
        phase_next = PH_HDR0;
      end else begin
        remaining_next = pay_len_next;
        phase_next     = PH_DATA;
      end
    end
  end

  // result record from the updated header fields
  always_comb begin
    res.data_byte     = data_out;
    res.fin_flag      = hdr0_next[7];
    res.rsv_bits      = hdr0_next[6:4];
    res.opcode        = hdr0_next[3:0];
    res.was_masked    = mask_on_next;
    res.frame_length  = pay_len_next;
    res.header_length = hdr_count_next;
    res.first_byte    = first_flag;
    res.last_byte     = last_flag;
    res.empty_frame   = empty_flag;
  end

  assign res_valid = take && emit;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      hdr_count <= 4'd0;
      hdr0      <= 8'd0;
      mask_on   <= 1'b0;
      pay_len   <= 64'd0;
      remaining <= 64'd0;
      mask_key  <= 32'd0;
      mask_idx  <= 2'd0;
    end else if (take) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      hdr0      <= hdr0_next;
      mask_on   <= mask_on_next;
      pay_len   <= pay_len_next;
      remaining <= remaining_next;
      mask_key  <= mask_key_next;
      mask_idx  <= mask_idx_next;
    end
  end

endmodule

[rtl/wsfd_out_buf.sv]
// ----------------------------------------------------------------------------
// wsfd_out_buf: result register with skid stage
// Output register plus one skid entry, so the parser keeps taking bytes
// while a result waits for the receiver, until the skid entry is filled.
// ----------------------------------------------------------------------------
module wsfd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsfd_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfd_pkg::result_t out_data
);

  logic              skid_valid;
  wsfd_pkg::result_t skid_data;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // control: output register first, skid entry when it is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[rtl/wsfd_checker.sv]
// ----------------------------------------------------------------------------
// wsfd_checker: port-level checks of the frame decoder
// Watches the result channel for stall behaviour, reset and the
// consistency of empty-frame, header-length and one-byte-frame marks.
// ----------------------------------------------------------------------------
module wsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic [63:0] frame_length,
  input logic [3:0]  header_length,
  input logic        first_byte,
  input logic        last_byte,
  input logic        empty_frame
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(frame_length))
    else $error("stalled result changed");

  // nothing offered straight after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // empty frame is a single zero byte of length zero
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |->
      first_byte && last_byte && data_byte == 8'd0 && frame_length == 64'd0)
    else $error("malformed empty frame result");

  // header length is a legal header size
  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> header_length == 4'd2 || header_length == 4'd4 ||
      header_length == 4'd6 || header_length == 4'd8 ||
      header_length == 4'd10 || header_length == 4'd14)
    else $error("illegal header length");

  // a payload byte of a one-byte frame is both first and last
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_length == 64'd1 |-> first_byte && last_byte)
    else $error("one-byte frame not marked first and last");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .data_byte     (result.data_byte),
  .frame_length  (result.frame_length),
  .header_length (result.header_length),
  .first_byte    (result.first_byte),
  .last_byte     (result.last_byte),
  .empty_frame   (result.empty_frame)
);
